// ----- rtl/core/ntag_pkg.sv -----
// ----------------------------------------------------------------------------
// ntag_pkg
// Shared widths, register map and configuration types for the transpose
// address generator.
// ----------------------------------------------------------------------------
package ntag_pkg;

  localparam int CFG_AXES = 4;
  localparam int SIZE_W   = 9;
  localparam int IDX_W    = 8;
  localparam int POS_W    = 2;
  localparam int ORDER_W  = 8;
  localparam int ADDR_W   = 32;
  localparam int ELEM_W   = 32;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  localparam int MAX_AXES_DEFAULT   = 4;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1);
  localparam logic [SIZE_W-1:0]  SIZE_MAX    = SIZE_W'(256);
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(228);

  typedef enum logic [2:0] {
    REG_SIZE_AXIS0 = 3'd0,
    REG_SIZE_AXIS1 = 3'd1,
    REG_SIZE_AXIS2 = 3'd2,
    REG_SIZE_AXIS3 = 3'd3,
    REG_AXIS_ORDER = 3'd4
  } ntag_reg_t;

  typedef struct packed {
    logic                                busy;
    logic                                order_error;
    logic [CFG_AXES-1:0][SIZE_W-1:0]     axis_size;
    logic [CFG_AXES-1:0][ADDR_W-1:0]     in_stride;
  } ntag_derived_t;

endpackage

// ----- rtl/core/ntag_if.sv -----
// ----------------------------------------------------------------------------
// ntag_if
// Valid/ready channels of the transpose address generator: element beats in,
// address beats out.
// ----------------------------------------------------------------------------
interface ntag_elem_if
  import ntag_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] elem_value;

  modport source (output valid, output elem_value, input ready);
  modport sink   (input valid, input elem_value, output ready);
endinterface

interface ntag_addr_if
  import ntag_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] out_address;
  logic [ELEM_W-1:0] out_value;
  logic              last_elem;
  logic              order_error;

  modport source (output valid, output out_address, output out_value,
                  output last_elem, output order_error, input ready);
  modport sink   (input valid, input out_address, input out_value,
                  input last_elem, input order_error, output ready);
endinterface

// ----- rtl/core/ntag_cfg.sv -----
// ----------------------------------------------------------------------------
// ntag_cfg
// APB register file plus the derived per-axis sizes, order check and input
// strides, rebuilt through registered stages after every write.
// ----------------------------------------------------------------------------
module ntag_cfg
  import ntag_pkg::*;
#(
  parameter int MAX_AXES = MAX_AXES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ntag_derived_t      derived
);

  localparam int NumAxes = (MAX_AXES < CFG_AXES) ? MAX_AXES : CFG_AXES;
  localparam int SettleW = $clog2(NumAxes + 3);
  localparam logic [SettleW-1:0] SettleLoad = SettleW'(NumAxes + 2);

  logic [CFG_AXES-1:0][SIZE_W-1:0] size_reg;
  logic [ORDER_W-1:0]              order_reg;

  logic [CFG_AXES-1:0][SIZE_W-1:0] eff_size, eff_size_next;
  logic [CFG_AXES-1:0][POS_W-1:0]  pos, pos_next;
  logic                            order_err, order_err_next;
  logic [CFG_AXES-1:0][SIZE_W-1:0] pos_size, pos_size_next;
  logic [CFG_AXES-1:0][ADDR_W-1:0] out_stride, out_stride_next;
  logic [CFG_AXES-1:0][ADDR_W-1:0] in_stride, in_stride_next;
  logic [SettleW-1:0]              settle, settle_next;

  ntag_reg_t reg_sel;
  logic      wr_en;

  assign reg_sel = ntag_reg_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < CFG_AXES; a++) begin
        size_reg[a] <= SIZE_RESET;
      end
      order_reg <= ORDER_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SIZE_AXIS0: size_reg[0] <= pwdata[SIZE_W-1:0];
        REG_SIZE_AXIS1: size_reg[1] <= pwdata[SIZE_W-1:0];
        REG_SIZE_AXIS2: size_reg[2] <= pwdata[SIZE_W-1:0];
        REG_SIZE_AXIS3: size_reg[3] <= pwdata[SIZE_W-1:0];
        REG_AXIS_ORDER: order_reg   <= pwdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SIZE_AXIS0: prdata = PDATA_W'(size_reg[0]);
      REG_SIZE_AXIS1: prdata = PDATA_W'(size_reg[1]);
      REG_SIZE_AXIS2: prdata = PDATA_W'(size_reg[2]);
      REG_SIZE_AXIS3: prdata = PDATA_W'(size_reg[3]);
      REG_AXIS_ORDER: prdata = PDATA_W'(order_reg);
      default:        prdata = '0;
    endcase
  end

  // clamped sizes, order fields and permutation check
  always_comb begin
    logic [CFG_AXES-1:0] seen;
    seen           = '0;
    order_err_next = 1'b0;
    for (int a = 0; a < CFG_AXES; a++) begin
      if (a >= NumAxes || size_reg[a] == '0) begin
        eff_size_next[a] = SIZE_RESET;
      end else if (size_reg[a] > SIZE_MAX) begin
        eff_size_next[a] = SIZE_MAX;
      end else begin
        eff_size_next[a] = size_reg[a];
      end
      pos_next[a] = order_reg[POS_W*a +: POS_W];
    end
    for (int k = 0; k < NumAxes; k++) begin
      if (int'(pos_next[k]) >= NumAxes || seen[pos_next[k]]) begin
        order_err_next = 1'b1;
      end else begin
        seen[pos_next[k]] = 1'b1;
      end
    end
  end

  // output-position sizes, suffix-product strides, inverse map to input axes
  always_comb begin
    for (int k = 0; k < CFG_AXES; k++) begin
      pos_size_next[k] = (k < NumAxes) ? eff_size[pos[k]] : SIZE_RESET;
    end
    for (int k = 0; k < CFG_AXES - 1; k++) begin
      if (k >= NumAxes - 1) begin
        out_stride_next[k] = ADDR_W'(1);
      end else begin
        out_stride_next[k] = ADDR_W'(out_stride[k+1] * pos_size[k+1]);
      end
    end
    out_stride_next[CFG_AXES-1] = ADDR_W'(1);
    for (int a = 0; a < CFG_AXES; a++) begin
      in_stride_next[a] = '0;
      for (int k = 0; k < NumAxes; k++) begin
        if (pos[k] == POS_W'(a)) begin
          in_stride_next[a] = out_stride[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    eff_size   <= eff_size_next;
    pos        <= pos_next;
    order_err  <= order_err_next;
    pos_size   <= pos_size_next;
    out_stride <= out_stride_next;
    in_stride  <= in_stride_next;
  end

  // hold off beats until the derived values have caught up
  always_comb begin
    if (wr_en) begin
      settle_next = SettleLoad;
    end else if (settle != '0) begin
      settle_next = settle - SettleW'(1);
    end else begin
      settle_next = settle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SettleLoad;
    end else begin
      settle <= settle_next;
    end
  end

  assign derived.busy        = (settle != '0);
  assign derived.order_error = order_err;
  assign derived.axis_size   = eff_size;
  assign derived.in_stride   = in_stride;

endmodule

// ----- rtl/core/nd_transpose_address_gen.sv -----
// ----------------------------------------------------------------------------
// nd_transpose_address_gen
// Address generator for an axis-permuting transpose of an array of up to four
// dimensions.
// ----------------------------------------------------------------------------
// Takes one element beat per cycle in row-major input order while the output
// accepts and no register rebuild is pending, and returns its flat address in
// the transposed array with the value, a last-element flag and an order-error
// flag through the s1, s2 and s3 registers. The per-axis counters advance in
// the accept cycle, one stage forms the up-to-four index-by-stride products,
// the next sums them into the output register. Strides are rebuilt from the
// registers by a short multiply chain, so elem ready stays low after reset
// and after every register write until the derived values have caught up.
module nd_transpose_address_gen
  import ntag_pkg::*;
#(
  parameter int MAX_AXES   = MAX_AXES_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  ntag_elem_if.sink          elem,
  ntag_addr_if.source        addr,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int NumAxes = (MAX_AXES < CFG_AXES) ? MAX_AXES : CFG_AXES;
  localparam logic [ELEM_W-1:0] ValueMask =
    ELEM_W'((65'd1 << DATA_WIDTH) - 65'd1);

  ntag_derived_t derived;

  ntag_cfg #(
    .MAX_AXES (MAX_AXES)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .derived (derived)
  );

  logic [NumAxes-1:0][IDX_W-1:0] idx, idx_next;
  logic                          wrap;

  logic                          s1_valid;
  logic [NumAxes-1:0][IDX_W-1:0] s1_idx;
  logic [ELEM_W-1:0]             s1_value;
  logic                          s1_last;

  logic                           s2_valid;
  logic [NumAxes-1:0][ADDR_W-1:0] s2_prod;
  logic [ELEM_W-1:0]              s2_value;
  logic                           s2_last;

  logic              s3_valid;
  logic [ADDR_W-1:0] s3_address;
  logic [ELEM_W-1:0] s3_value;
  logic              s3_last;
  logic              s3_error;

  logic [NumAxes-1:0][ADDR_W-1:0] prod_next;
  logic [ADDR_W-1:0]              sum;
  logic                           go1, go2, go3, accept;

  assign go3    = !s3_valid || addr.ready;
  assign go2    = !s2_valid || go3;
  assign go1    = !s1_valid || go2;
  assign accept = elem.valid && elem.ready;

  assign elem.ready = go1 && !derived.busy;

  // odometer over the input axes, fastest axis last
  always_comb begin
    wrap     = 1'b1;
    idx_next = idx;
    for (int a = NumAxes - 1; a >= 0; a--) begin
      if (wrap) begin
        if (({1'b0, idx[a]} + SIZE_W'(1)) >= derived.axis_size[a]) begin
          idx_next[a] = '0;
        end else begin
          idx_next[a] = idx[a] + IDX_W'(1);
          wrap        = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= idx_next;
    end
  end

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      prod_next[a] = ADDR_W'(s1_idx[a] * derived.in_stride[a]);
    end
    sum = '0;
    for (int a = 0; a < NumAxes; a++) begin
      sum = sum + s2_prod[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (go1) begin
        s1_valid <= accept;
      end
      if (go2) begin
        s2_valid <= s1_valid;
      end
      if (go3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      s1_idx   <= idx;
      s1_value <= elem.elem_value & ValueMask;
      s1_last  <= wrap;
    end
    if (go2) begin
      s2_prod  <= prod_next;
      s2_value <= s1_value;
      s2_last  <= s1_last;
    end
    if (go3) begin
      s3_address <= derived.order_error ? '0 : sum;
      s3_value   <= s2_value;
      s3_last    <= s2_last;
      s3_error   <= derived.order_error;
    end
  end

  assign addr.valid       = s3_valid;
  assign addr.out_address = s3_address;
  assign addr.out_value   = s3_value;
  assign addr.last_elem   = s3_last;
  assign addr.order_error = s3_error;

endmodule
